// ===== design/nta_pkg.sv =====
// Shared types, constants and lookup tables for the number to ASCII formatter.
package nta_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int HEX_NIBBLES = (VALUE_WIDTH + 3) / 4;
    localparam int HEX_BITS    = HEX_NIBBLES * 4;
    localparam int DEC_DIGITS  = 20;
    localparam int DEC_BITS    = DEC_DIGITS * 4;
    localparam int CNT_MAX     = (VALUE_WIDTH > DEC_DIGITS) ? VALUE_WIDTH : DEC_DIGITS;
    localparam int CNT_W       = $clog2(CNT_MAX);

    typedef logic [7:0]          t_byte;
    typedef logic [1:0]          t_mode;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [HEX_BITS-1:0] t_bin;
    typedef logic [DEC_BITS-1:0] t_bcd;

    localparam t_mode MODE_CHAR = 2'd0;
    localparam t_mode MODE_HEX  = 2'd1;
    localparam t_mode MODE_DEC  = 2'd2;

    localparam t_byte ASCII_ZERO = 8'h30;
    localparam t_byte ASCII_X    = 8'h78;
    localparam t_byte ASCII_CR   = 8'h0D;
    localparam t_byte ASCII_LF   = 8'h0A;

    typedef logic [2:0] t_src;
    localparam t_src SRC_ZERO = 3'd0;
    localparam t_src SRC_X    = 3'd1;
    localparam t_src SRC_CR   = 3'd2;
    localparam t_src SRC_CHAR = 3'd3;
    localparam t_src SRC_HEX  = 3'd4;
    localparam t_src SRC_DEC  = 3'd5;

    localparam t_byte HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef struct packed {
        logic load;
        logic dd_step;
        logic shift_hex;
        logic shift_dec;
        logic emit;
        logic last;
        t_src src;
    } t_cmd;

    typedef struct packed {
        t_mode in_mode;
        logic  in_is_lf;
        logic  dec_top_zero;
    } t_sts;

endpackage

// ===== design/nta_dp.sv =====
// Datapath of the formatter: operand registers, double-dabble converter and output register.
module nta_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nta_pkg::t_cmd        i_cmd,
    output nta_pkg::t_sts        o_sts,
    input  nta_pkg::t_mode       i_mode,
    input  logic [7:0]           i_char_code,
    input  logic [63:0]          i_value,
    output logic                 o_valid,
    output logic [7:0]           o_tx_byte,
    output logic                 o_last
);
    import nta_pkg::*;

    t_byte r_char;
    t_bin  r_bin;
    t_bcd  r_bcd;
    logic  r_valid;
    t_byte r_tx_byte;
    logic  r_last;
    t_byte n_byte;

    function automatic t_bcd dd_adjust(input t_bcd b);
        t_bcd r;
        r = b;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r[i*4 +: 4] >= 4'd5) begin
                r[i*4 +: 4] = r[i*4 +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    assign o_sts.in_mode      = i_mode;
    assign o_sts.in_is_lf     = (i_char_code == ASCII_LF);
    assign o_sts.dec_top_zero = (r_bcd[DEC_BITS-1 -: 4] == 4'd0);

    always_comb begin
        case (i_cmd.src)
            SRC_ZERO: n_byte = ASCII_ZERO;
            SRC_X:    n_byte = ASCII_X;
            SRC_CR:   n_byte = ASCII_CR;
            SRC_CHAR: n_byte = r_char;
            SRC_HEX:  n_byte = HEX_DIGITS[r_bin[HEX_BITS-1 -: 4]];
            SRC_DEC:  n_byte = ASCII_ZERO | {4'd0, r_bcd[DEC_BITS-1 -: 4]};
            default:  n_byte = ASCII_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_char_code;
            r_bin  <= HEX_BITS'(i_value[VALUE_WIDTH-1:0]);
            r_bcd  <= '0;
        end else if (i_cmd.dd_step) begin
            r_bin <= {r_bin[HEX_BITS-2:0], 1'b0};
            r_bcd <= {dd_adjust(r_bcd) << 1} | DEC_BITS'(r_bin[VALUE_WIDTH-1]);
        end else begin
            if (i_cmd.shift_hex) begin
                r_bin <= {r_bin[HEX_BITS-5:0], 4'd0};
            end
            if (i_cmd.shift_dec) begin
                r_bcd <= {r_bcd[DEC_BITS-5:0], 4'd0};
            end
        end
        if (i_cmd.emit) begin
            r_tx_byte <= n_byte;
            r_last    <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_valid   = r_valid;
    assign o_tx_byte = r_tx_byte;
    assign o_last    = r_last;

endmodule

// ===== design/nta_ctrl.sv =====
// Controller state machine that sequences the formatter datapath.
module nta_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  nta_pkg::t_sts i_sts,
    output nta_pkg::t_cmd o_cmd
);
    import nta_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CR   = 4'd1;
    localparam logic [3:0] S_CHR  = 4'd2;
    localparam logic [3:0] S_PFX0 = 4'd3;
    localparam logic [3:0] S_PFXX = 4'd4;
    localparam logic [3:0] S_HEX  = 4'd5;
    localparam logic [3:0] S_DD   = 4'd6;
    localparam logic [3:0] S_SKIP = 4'd7;
    localparam logic [3:0] S_DEC  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cnt       r_cnt;
    t_cnt       n_cnt;
    logic       cnt_zero;

    assign cnt_zero = (r_cnt == '0);
    assign busy     = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.src = SRC_ZERO;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (i_sts.in_mode)
                        MODE_CHAR: n_state = i_sts.in_is_lf ? S_CR : S_CHR;
                        MODE_HEX:  n_state = S_PFX0;
                        MODE_DEC: begin
                            n_state = S_DD;
                            n_cnt   = CNT_W'(VALUE_WIDTH - 1);
                        end
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CR: begin
                o_cmd.emit = 1'b1;
                o_cmd.src  = SRC_CR;
                n_state    = S_CHR;
            end
            S_CHR: begin
                o_cmd.emit = 1'b1;
                o_cmd.last = 1'b1;
                o_cmd.src  = SRC_CHAR;
                n_state    = S_IDLE;
            end
            S_PFX0: begin
                o_cmd.emit = 1'b1;
                o_cmd.src  = SRC_ZERO;
                n_state    = S_PFXX;
            end
            S_PFXX: begin
                o_cmd.emit = 1'b1;
                o_cmd.src  = SRC_X;
                n_state    = S_HEX;
                n_cnt      = CNT_W'(HEX_NIBBLES - 1);
            end
            S_HEX: begin
                o_cmd.emit      = 1'b1;
                o_cmd.src       = SRC_HEX;
                o_cmd.shift_hex = 1'b1;
                if (cnt_zero) begin
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_cnt = r_cnt - t_cnt'(1);
                end
            end
            S_DD: begin
                o_cmd.dd_step = 1'b1;
                if (cnt_zero) begin
                    n_state = S_SKIP;
                    n_cnt   = CNT_W'(DEC_DIGITS - 1);
                end else begin
                    n_cnt = r_cnt - t_cnt'(1);
                end
            end
            S_SKIP: begin
                if (i_sts.dec_top_zero && !cnt_zero) begin
                    o_cmd.shift_dec = 1'b1;
                    n_cnt           = r_cnt - t_cnt'(1);
                end else begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.emit      = 1'b1;
                o_cmd.src       = SRC_DEC;
                o_cmd.shift_dec = 1'b1;
                if (cnt_zero) begin
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_cnt = r_cnt - t_cnt'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== design/number_to_ascii_formatter_unit.sv =====
// Top level of the number to ASCII formatter: controller plus datapath.
// A transaction starts when start is high while busy is low. A character
// request gives one byte, or two for a line feed, in the cycles right after
// acceptance. A hex request gives eighteen bytes, one per cycle. A decimal
// request first runs 64 double-dabble steps, one per cycle, then skips leading
// zero digits, then gives one digit per cycle. Skipped and sent digits always
// add up to twenty, so how long busy stays high does not depend on the value.
// Each byte appears for a single cycle with o_valid high and o_last marks the
// final byte; the receiver cannot stall, so it must take every byte as it comes.
// A request with mode 3 is accepted and gives no bytes.
module number_to_ascii_formatter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [63:0] i_value,
    output logic        o_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_last
);
    import nta_pkg::*;

    t_cmd cmd;
    t_sts sts;

    nta_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    nta_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last)
    );

endmodule
